@@ sv/sbcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcc_pkg
// Shared types and constants of the segment box collision check core.
// ----------------------------------------------------------------------------
package sbcc_pkg;

	// default sizes
	localparam int MAX_OBSTACLES_DEF = 64;
	localparam int DIMS_DEF          = 3;
	localparam int MAX_STEPS_DEF     = 65536;

	// configuration register indexes
	localparam logic [2:0] CFG_ACTIVE_DIMS    = 3'd0;
	localparam logic [2:0] CFG_OBSTACLE_COUNT = 3'd1;
	localparam logic [2:0] CFG_ROBOT_SIZE_X   = 3'd2;
	localparam logic [2:0] CFG_ROBOT_SIZE_Y   = 3'd3;
	localparam logic [2:0] CFG_ROBOT_SIZE_Z   = 3'd4;
	localparam logic [2:0] CFG_STEP_LENGTH    = 3'd5;

	// transaction function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// iteration lengths of the root and divider units
	localparam logic [6:0] SQRT_ITERS  = 7'd34;
	localparam logic [6:0] NDIV_ITERS  = 7'd34;
	localparam logic [6:0] IDIV_ITERS  = 7'd79;

	typedef enum logic [1:0] {
		ST_LOADED   = 2'd0,
		ST_CLEAR    = 2'd1,
		ST_COLLIDE  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_SQ,
		OP_SQACC,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_NDIV_INIT,
		OP_DIV,
		OP_MUL,
		OP_IDIV_INIT,
		OP_INC_SET,
		OP_WALK_INIT,
		OP_PT_INIT,
		OP_RD,
		OP_CMP,
		OP_ADV,
		OP_END_INIT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_SQ,
		S_SQACC,
		S_SQRT_INIT,
		S_SQRT,
		S_NDIV_INIT,
		S_NDIV,
		S_CHKN,
		S_MUL,
		S_IDIV_INIT,
		S_IDIV,
		S_INC_SET,
		S_WALK_INIT,
		S_PT_INIT,
		S_RD,
		S_CMP,
		S_ADV,
		S_END_INIT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t     op;
		logic    emit;
		status_t res;
	} cmd_t;

	typedef struct packed {
		logic last_dim;
		logic last_ob;
		logic cnt_zero;
		logic cmp_fail;
		logic iter_done;
		logic too_long;
		logic n_zero;
		logic last_point;
	} stat_t;

endpackage

@@ sv/sbcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcc_ctrl
// Sequencer: steps the datapath through load, length, walk and box checks.
// ----------------------------------------------------------------------------
module sbcc_ctrl
	import sbcc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  func,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t res_q, res_d;
	logic    end_q, end_d;
	logic    out_valid_q;
	logic    out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// hold state, pending result code and end point flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_LOADED;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			end_q   <= end_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		end_d    = end_q;
		cmd.op   = OP_NONE;
		cmd.emit = 1'b0;
		cmd.res  = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = (func == FUNC_LOAD) ? S_LOAD : S_SQ;
				end
			end
			S_LOAD: begin
				cmd.op  = OP_LOAD;
				res_d   = ST_LOADED;
				state_d = S_DONE;
			end
			S_SQ: begin
				cmd.op  = OP_SQ;
				state_d = S_SQACC;
			end
			S_SQACC: begin
				cmd.op  = OP_SQACC;
				state_d = st.last_dim ? S_SQRT_INIT : S_SQ;
			end
			S_SQRT_INIT: begin
				cmd.op  = OP_SQRT_INIT;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (st.iter_done)
					state_d = S_NDIV_INIT;
			end
			S_NDIV_INIT: begin
				cmd.op  = OP_NDIV_INIT;
				state_d = S_NDIV;
			end
			S_NDIV: begin
				cmd.op = OP_DIV;
				if (st.iter_done)
					state_d = S_CHKN;
			end
			S_CHKN: begin
				if (st.too_long) begin
					res_d   = ST_TOO_LONG;
					state_d = S_DONE;
				end else if (st.n_zero) begin
					state_d = S_END_INIT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_IDIV_INIT;
			end
			S_IDIV_INIT: begin
				cmd.op  = OP_IDIV_INIT;
				state_d = S_IDIV;
			end
			S_IDIV: begin
				cmd.op = OP_DIV;
				if (st.iter_done)
					state_d = S_INC_SET;
			end
			S_INC_SET: begin
				cmd.op  = OP_INC_SET;
				state_d = st.last_dim ? S_WALK_INIT : S_MUL;
			end
			S_WALK_INIT: begin
				cmd.op  = OP_WALK_INIT;
				end_d   = 1'b0;
				state_d = S_PT_INIT;
			end
			S_PT_INIT: begin
				cmd.op = OP_PT_INIT;
				// no boxes: the point is clear
				if (st.cnt_zero) begin
					if (end_q) begin
						res_d   = ST_CLEAR;
						state_d = S_DONE;
					end else begin
						state_d = S_ADV;
					end
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.op  = OP_RD;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op = OP_CMP;
				priority if (!st.cmp_fail && st.last_dim) begin
					res_d   = ST_COLLIDE;
					state_d = S_DONE;
				end else if (st.cmp_fail && st.last_ob) begin
					if (end_q) begin
						res_d   = ST_CLEAR;
						state_d = S_DONE;
					end else begin
						state_d = S_ADV;
					end
				end else if (st.cmp_fail) begin
					state_d = S_RD;
				end else begin
					state_d = S_RD;
				end
			end
			S_ADV: begin
				cmd.op  = OP_ADV;
				state_d = st.last_point ? S_END_INIT : S_PT_INIT;
			end
			S_END_INIT: begin
				cmd.op  = OP_END_INIT;
				end_d   = 1'b1;
				state_d = S_PT_INIT;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result emitted over an untaken result");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting a transaction");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_RD))
		else $error("compare without a table read");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");
`endif

endmodule

@@ sv/sbcc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcc_dp
// Datapath: registers, box table, squarer, root and divider units, walk.
// ----------------------------------------------------------------------------
module sbcc_dp
	import sbcc_pkg::*;
#(
	parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
	parameter int DIMS          = DIMS_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic [5:0]         obstacle_index,
	input  logic [1:0]         dim_index,
	input  logic signed [31:0] box_center,
	input  logic [30:0]        box_size,
	input  logic signed [31:0] from_x,
	input  logic signed [31:0] from_y,
	input  logic signed [31:0] from_z,
	input  logic signed [31:0] to_x,
	input  logic signed [31:0] to_y,
	input  logic signed [31:0] to_z,
	input  cmd_t               cmd,
	output stat_t              st,
	output logic [1:0]         status,
	output logic [31:0]        path_length
);

	localparam int DEPTH = MAX_OBSTACLES * DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_OBSTACLES + 1);

	// configuration
	logic [1:0]  active_dims_q;
	logic [6:0]  obstacle_count_q;
	logic [30:0] robot_q [3];
	logic [30:0] step_q;

	// captured transaction
	logic [5:0]         ob_q;
	logic [1:0]         dm_q;
	logic signed [31:0] ctr_q;
	logic [30:0]        size_q;
	logic signed [31:0] from_q [3];
	logic signed [31:0] to_q [3];

	// arithmetic state
	logic [1:0]  dcnt_q;
	logic [65:0] prod_q;
	logic [65:0] sum_q;
	logic [67:0] rad_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [78:0] dvd_q;
	logic [33:0] dvs_q;
	logic [33:0] drem_q;
	logic [6:0]  itc_q;
	logic [6:0]  len_q;
	logic [33:0] n_q;
	logic [33:0] kcnt_q;
	logic signed [49:0] inc_q [3];
	logic signed [50:0] acc_q [3];
	logic        end_q;
	logic [CW-1:0] ocnt_q;
	logic [AW-1:0] base_q;

	// box table
	logic [31:0] mem_c [DEPTH];
	logic [30:0] mem_s [DEPTH];
	logic signed [31:0] rdc_q;
	logic [30:0]        rds_q;

	logic [1:0]    dims_eff;
	logic [CW-1:0] cnt_eff;
	logic [30:0]   step_eff;
	logic [32:0]   mag [3];
	logic          neg [3];
	logic [32:0]   mop_b;
	logic [37:0]   srem_t, strial;
	logic          sge;
	logic [34:0]   drem_t;
	logic          dge;
	logic signed [34:0] pt;
	logic signed [35:0] cdiff;
	logic [35:0]   cmag;
	logic [31:0]   lim;
	logic          fail;
	logic [48:0]   qmag;
	logic          ld_ok;
	logic [31:0]   ld_idx;

	// effective register values
	always_comb begin
		if (active_dims_q == 2'd0)
			dims_eff = 2'd1;
		else if (active_dims_q > 2'(DIMS))
			dims_eff = 2'(DIMS);
		else
			dims_eff = active_dims_q;
		if ({25'd0, obstacle_count_q} > 32'(MAX_OBSTACLES))
			cnt_eff = CW'(MAX_OBSTACLES);
		else
			cnt_eff = CW'(obstacle_count_q);
		step_eff = (step_q == 31'd0) ? 31'd1 : step_q;
	end

	// per dimension magnitude and sign of the segment
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [32:0] df;
			df     = {to_q[i][31], to_q[i]} - {from_q[i][31], from_q[i]};
			neg[i] = df[32];
			mag[i] = df[32] ? 33'(-df) : 33'(df);
		end
	end

	assign mop_b = (cmd.op == OP_MUL) ? {2'b00, step_eff} : mag[dcnt_q];

	// root step: one result bit per cycle
	assign srem_t = {rem_q, rad_q[67:66]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = (srem_t >= strial);

	// divider step: one quotient bit per cycle
	assign drem_t = {drem_q, dvd_q[78]};
	assign dge    = (drem_t >= {1'b0, dvs_q});

	// point coordinate and box test of the current dimension
	always_comb begin
		if (end_q)
			pt = {{3{to_q[dcnt_q][31]}}, to_q[dcnt_q]};
		else
			pt = acc_q[dcnt_q][50:16];
		cdiff = {{4{rdc_q[31]}}, rdc_q} - {pt[34], pt};
		cmag  = cdiff[35] ? 36'(-cdiff) : 36'(cdiff);
		lim   = {1'b0, rds_q} + {1'b0, robot_q[dcnt_q]};
		fail  = ({cmag, 1'b0} > {5'd0, lim});
	end

	assign qmag   = dvd_q[48:0];
	assign ld_ok  = (32'(ob_q) < 32'(MAX_OBSTACLES)) && (32'(dm_q) < 32'(DIMS));
	assign ld_idx = 32'(ob_q) * 32'(DIMS) + 32'(dm_q);

	// status to the sequencer
	always_comb begin
		st.last_dim   = (dcnt_q == dims_eff - 2'd1);
		st.last_ob    = (ocnt_q == cnt_eff - CW'(1));
		st.cnt_zero   = (cnt_eff == '0);
		st.cmp_fail   = fail;
		st.iter_done  = (itc_q == len_q - 7'd1);
		st.too_long   = (dvd_q[33:0] > 34'(MAX_STEPS));
		st.n_zero     = (dvd_q[33:0] == 34'd0);
		st.last_point = (kcnt_q == n_q - 34'd1);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q    <= 2'd2;
			obstacle_count_q <= 7'd0;
			robot_q[0]       <= 31'd0;
			robot_q[1]       <= 31'd0;
			robot_q[2]       <= 31'd0;
			step_q           <= 31'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_DIMS:    active_dims_q    <= cfg_data[1:0];
				CFG_OBSTACLE_COUNT: obstacle_count_q <= cfg_data[6:0];
				CFG_ROBOT_SIZE_X:   robot_q[0]       <= cfg_data;
				CFG_ROBOT_SIZE_Y:   robot_q[1]       <= cfg_data;
				CFG_ROBOT_SIZE_Z:   robot_q[2]       <= cfg_data;
				CFG_STEP_LENGTH:    step_q           <= cfg_data;
				default: ;
			endcase
		end
	end

	// box table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && ld_ok) begin
			mem_c[AW'(ld_idx)] <= ctr_q;
			mem_s[AW'(ld_idx)] <= size_q;
		end
		if (cmd.op == OP_RD) begin
			rdc_q <= mem_c[base_q + AW'(dcnt_q)];
			rds_q <= mem_s[base_q + AW'(dcnt_q)];
		end
	end

	// advance the datapath on each command
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				ob_q      <= obstacle_index;
				dm_q      <= dim_index;
				ctr_q     <= box_center;
				size_q    <= box_size;
				from_q[0] <= from_x;
				from_q[1] <= from_y;
				from_q[2] <= from_z;
				to_q[0]   <= to_x;
				to_q[1]   <= to_y;
				to_q[2]   <= to_z;
				sum_q     <= 66'd0;
				dcnt_q    <= 2'd0;
			end
			OP_SQ, OP_MUL: prod_q <= mag[dcnt_q] * mop_b;
			OP_SQACC: begin
				sum_q  <= sum_q + prod_q;
				dcnt_q <= dcnt_q + 2'd1;
			end
			OP_SQRT_INIT: begin
				rad_q  <= {2'b00, sum_q};
				rem_q  <= 36'd0;
				root_q <= 34'd0;
				itc_q  <= 7'd0;
				len_q  <= SQRT_ITERS;
			end
			OP_SQRT: begin
				rad_q  <= {rad_q[65:0], 2'b00};
				rem_q  <= sge ? 36'(srem_t - strial) : srem_t[35:0];
				root_q <= {root_q[32:0], sge};
				itc_q  <= itc_q + 7'd1;
			end
			OP_NDIV_INIT: begin
				dvd_q  <= {root_q, 45'd0};
				dvs_q  <= {3'b000, step_eff};
				drem_q <= 34'd0;
				itc_q  <= 7'd0;
				len_q  <= NDIV_ITERS;
				dcnt_q <= 2'd0;
			end
			OP_DIV: begin
				drem_q <= dge ? 34'(drem_t - {1'b0, dvs_q}) : drem_t[33:0];
				dvd_q  <= {dvd_q[77:0], dge};
				itc_q  <= itc_q + 7'd1;
				if (len_q == NDIV_ITERS && st.iter_done)
					n_q <= {dvd_q[32:0], dge};
			end
			OP_IDIV_INIT: begin
				dvd_q  <= {prod_q[62:0], 16'd0};
				dvs_q  <= root_q;
				drem_q <= 34'd0;
				itc_q  <= 7'd0;
				len_q  <= IDIV_ITERS;
			end
			OP_INC_SET: begin
				inc_q[dcnt_q] <= neg[dcnt_q] ? -$signed({1'b0, qmag})
					: $signed({1'b0, qmag});
				acc_q[dcnt_q] <= {{3{from_q[dcnt_q][31]}}, from_q[dcnt_q], 16'd0};
				dcnt_q        <= dcnt_q + 2'd1;
			end
			OP_WALK_INIT: begin
				kcnt_q <= 34'd0;
				end_q  <= 1'b0;
			end
			OP_PT_INIT: begin
				ocnt_q <= '0;
				base_q <= '0;
				dcnt_q <= 2'd0;
			end
			OP_CMP: begin
				if (fail || st.last_dim) begin
					ocnt_q <= ocnt_q + CW'(1);
					base_q <= base_q + AW'(DIMS);
					dcnt_q <= 2'd0;
				end else begin
					dcnt_q <= dcnt_q + 2'd1;
				end
			end
			OP_ADV: begin
				for (int i = 0; i < 3; i++)
					acc_q[i] <= acc_q[i] + 51'(inc_q[i]);
				kcnt_q <= kcnt_q + 34'd1;
			end
			OP_END_INIT: end_q <= 1'b1;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.res;
			if (cmd.res == ST_CLEAR)
				path_length <= (root_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : root_q[31:0];
			else
				path_length <= 32'd0;
		end
	end

endmodule

@@ sv/segment_box_collision_check_core.sv @@
`timescale 1ns / 1ps
// Load: captured on acceptance, written in S_LOAD, result registered from
// S_DONE. Query: squares and root for the length, a divide for the step
// count, one per active dim for the increments (one quotient bit a cycle),
// then up to (n+1) points, E table entries read each (one table read port).
// One transaction at a time; the next is taken once the result is registered.
// Reset sets configuration and control; the box table is not cleared.
// ----------------------------------------------------------------------------
// segment_box_collision_check_core
// Checks a discretised segment against a table of axis-aligned boxes.
// ----------------------------------------------------------------------------
module segment_box_collision_check_core
	import sbcc_pkg::*;
#(
	parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
	parameter int DIMS          = DIMS_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [5:0]         obstacle_index,
	input  logic [1:0]         dim_index,
	input  logic signed [31:0] box_center,
	input  logic [30:0]        box_size,
	input  logic signed [31:0] from_x,
	input  logic signed [31:0] from_y,
	input  logic signed [31:0] from_z,
	input  logic signed [31:0] to_x,
	input  logic signed [31:0] to_y,
	input  logic signed [31:0] to_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [31:0]        path_length
);

	cmd_t  cmd;
	stat_t st;

	// sequencer
	sbcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath
	sbcc_dp #(
		.MAX_OBSTACLES (MAX_OBSTACLES),
		.DIMS          (DIMS),
		.MAX_STEPS     (MAX_STEPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.obstacle_index (obstacle_index),
		.dim_index      (dim_index),
		.box_center     (box_center),
		.box_size       (box_size),
		.from_x         (from_x),
		.from_y         (from_y),
		.from_z         (from_z),
		.to_x           (to_x),
		.to_y           (to_y),
		.to_z           (to_z),
		.cmd            (cmd),
		.st             (st),
		.status         (status),
		.path_length    (path_length)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segment box collision check core. It fills the
// box table, then runs directed and random load and query transactions over
// several register settings. A scoreboard predicts each result from its own
// copy of the table and the registers, then compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import sbcc_pkg::*;

	localparam int TABLE_DEPTH = MAX_OBSTACLES_DEF * DIMS_DEF;
	localparam int CYCLE_LIMIT = 20000000;
	localparam longint WORLD   = 64'sd1 << 20;

	typedef struct {
		status_t     st;
		logic [31:0] len;
	} outcome_t;

	// ------------------------------------------------------------------------
	// scoreboard: predicts results and checks them in order
	// ------------------------------------------------------------------------
	class collision_scoreboard;
		logic [31:0] centre_tab[TABLE_DEPTH];
		logic [30:0] size_tab[TABLE_DEPTH];
		logic [1:0]  dims_reg;
		logic [6:0]  count_reg;
		logic [30:0] robot[3];
		logic [30:0] step_reg;
		outcome_t    awaited[$];
		int          errors;

		function new();
			dims_reg  = 2'd2;
			count_reg = 7'd0;
			robot[0]  = '0;
			robot[1]  = '0;
			robot[2]  = '0;
			step_reg  = 31'd655;
			errors    = 0;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void write_reg(input logic [2:0] idx, input logic [30:0] data);
			case (idx)
				CFG_ACTIVE_DIMS:    dims_reg  = data[1:0];
				CFG_OBSTACLE_COUNT: count_reg = data[6:0];
				CFG_ROBOT_SIZE_X:   robot[0]  = data;
				CFG_ROBOT_SIZE_Y:   robot[1]  = data;
				CFG_ROBOT_SIZE_Z:   robot[2]  = data;
				CFG_STEP_LENGTH:    step_reg  = data;
				default: ;
			endcase
		endfunction

		function int eff_dims();
			if (dims_reg == 2'd0) return 1;
			if (dims_reg > DIMS_DEF) return DIMS_DEF;
			return dims_reg;
		endfunction

		function int eff_count();
			return (count_reg > MAX_OBSTACLES_DEF) ? MAX_OBSTACLES_DEF : count_reg;
		endfunction

		function logic [63:0] eff_step();
			return (step_reg == 0) ? 64'd1 : {33'd0, step_reg};
		endfunction

		// floor root of the summed squares of the coordinate deltas
		function logic [63:0] seg_length(input longint fr[3], input longint to[3]);
			logic [127:0] sum, sq;
			logic [63:0]  m, res, cand;
			longint       dd;
			sum = '0;
			res = '0;
			for (int d = 0; d < eff_dims(); d++) begin
				dd  = to[d] - fr[d];
				m   = (dd < 0) ? -dd : dd;
				sq  = {64'd0, m} * {64'd0, m};
				sum = sum + sq;
			end
			for (int b = 34; b >= 0; b--) begin
				cand = res | (64'd1 << b);
				sq   = {64'd0, cand} * {64'd0, cand};
				if (sq <= sum) res = cand;
			end
			return res;
		endfunction

		function logic [63:0] step_count(input longint fr[3], input longint to[3]);
			return seg_length(fr, to) / eff_step();
		endfunction

		function bit point_hits(input longint p[3]);
			int          idx;
			bit          hit;
			longint      c, dd;
			logic [63:0] mg, lim;
			for (int ob = 0; ob < eff_count(); ob++) begin
				hit = 1;
				for (int d = 0; d < eff_dims(); d++) begin
					idx = ob * DIMS_DEF + d;
					c   = longint'($signed(centre_tab[idx]));
					lim = {33'd0, size_tab[idx]} + {33'd0, robot[d]};
					dd  = c - p[d];
					mg  = (dd < 0) ? -dd : dd;
					if ((mg << 1) > lim) begin
						hit = 0;
						break;
					end
				end
				if (hit) return 1;
			end
			return 0;
		endfunction

		function outcome_t predict_query(input longint fr[3], input longint to[3]);
			outcome_t    o;
			logic [63:0] seg_len, stp, n, m, num, q, r, mg;
			longint      dd, inc[3], acc[3], pt[3];
			o.st    = ST_CLEAR;
			o.len   = '0;
			stp     = eff_step();
			seg_len = seg_length(fr, to);
			n       = seg_len / stp;
			if (n > MAX_STEPS_DEF) begin
				o.st = ST_TOO_LONG;
				return o;
			end
			if (n > 0) begin
				for (int d = 0; d < eff_dims(); d++) begin
					dd     = to[d] - fr[d];
					m      = (dd < 0) ? -dd : dd;
					num    = m * stp;
					q      = num / seg_len;
					r      = num % seg_len;
					mg     = (q << 16) + ((r << 16) / seg_len);
					inc[d] = (dd < 0) ? -longint'(mg) : longint'(mg);
					acc[d] = fr[d] * 65536;
				end
				// walk the segment point by point
				for (logic [63:0] k = 0; k < n; k++) begin
					for (int d = 0; d < eff_dims(); d++) pt[d] = acc[d] >>> 16;
					if (point_hits(pt)) begin
						o.st = ST_COLLIDE;
						return o;
					end
					for (int d = 0; d < eff_dims(); d++) acc[d] += inc[d];
				end
			end
			if (point_hits(to)) begin
				o.st = ST_COLLIDE;
				return o;
			end
			o.len = (seg_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : seg_len[31:0];
			return o;
		endfunction

		function void note_input(input logic f, input logic [5:0] ob, input logic [1:0] dm,
				input logic [31:0] c, input logic [30:0] s,
				input longint fr[3], input longint to[3]);
			outcome_t o;
			int       idx;
			if (f == FUNC_LOAD) begin
				o.st  = ST_LOADED;
				o.len = '0;
				if (ob < MAX_OBSTACLES_DEF && dm < DIMS_DEF) begin
					idx = ob * DIMS_DEF + dm;
					centre_tab[idx] = c;
					size_tab[idx]   = s;
				end
			end else begin
				o = predict_query(fr, to);
			end
			awaited.push_back(o);
		endfunction

		task check(input logic [1:0] st, input logic [31:0] len);
			outcome_t o;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status %0d len %h", st, len));
			end else begin
				o = awaited.pop_front();
				if (st !== o.st)
					report($sformatf("status %0d, want %0d", st, o.st));
				if (len !== o.len)
					report($sformatf("path_length %h, want %h", len, o.len));
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [5:0]         obstacle_index;
	logic [1:0]         dim_index;
	logic signed [31:0] box_center;
	logic [30:0]        box_size;
	logic signed [31:0] from_x, from_y, from_z;
	logic signed [31:0] to_x, to_y, to_z;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [31:0]        path_length;

	collision_scoreboard sb = new();
	bit  rush;
	int  stall_left;
	int  cycles;

	segment_box_collision_check_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .obstacle_index(obstacle_index), .dim_index(dim_index),
		.box_center(box_center), .box_size(box_size),
		.from_x(from_x), .from_y(from_y), .from_z(from_z),
		.to_x(to_x), .to_y(to_y), .to_z(to_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .path_length(path_length)
	);

	always #4 clk = ~clk;

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function int draw_wait();
		return rush ? 0 : $urandom_range(0, 8);
	endfunction

	// note accepted input transactions
	always @(posedge clk) begin
		longint a[3], b[3];
		if (arst_n && in_valid && !in_stall) begin
			a[0] = longint'(from_x); a[1] = longint'(from_y); a[2] = longint'(from_z);
			b[0] = longint'(to_x);   b[1] = longint'(to_y);   b[2] = longint'(to_z);
			sb.note_input(func, obstacle_index, dim_index, box_center, box_size, a, b);
		end
	end

	// check accepted results and draw the next receiver hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check(status, path_length);
			stall_left = draw_wait();
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// driving tasks
	// ------------------------------------------------------------------------
	task drive_item(input logic f, input logic [5:0] ob, input logic [1:0] dm,
			input logic [31:0] c, input logic [30:0] s,
			input longint fr[3], input longint to[3]);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= f;
		obstacle_index <= ob;
		dim_index      <= dm;
		box_center     <= c;
		box_size       <= s;
		from_x <= fr[0][31:0]; from_y <= fr[1][31:0]; from_z <= fr[2][31:0];
		to_x   <= to[0][31:0]; to_y   <= to[1][31:0]; to_z   <= to[2][31:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function longint local_coord();
		return longint'($urandom_range(0, 2 * WORLD)) - WORLD;
	endfunction

	function longint extreme_coord();
		case ($urandom_range(0, 3))
			0: return -64'sd2147483648;
			1: return 64'sd2147483647;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	task send_load(input logic [5:0] ob, input logic [1:0] dm,
			input logic [31:0] c, input logic [30:0] s);
		longint a[3], b[3];
		for (int d = 0; d < 3; d++) begin
			a[d] = longint'($signed($urandom()));
			b[d] = longint'($signed($urandom()));
		end
		drive_item(FUNC_LOAD, ob, dm, c, s, a, b);
	endtask

	task send_query(input longint fr[3], input longint to[3]);
		drive_item(FUNC_QUERY, 6'($urandom()), 2'($urandom()), $urandom(),
			31'($urandom()), fr, to);
	endtask

	task random_load();
		logic [1:0]  dm;
		logic [31:0] c;
		logic [30:0] s;
		dm = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		c  = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(local_coord());
		s  = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 18));
		send_load(6'($urandom()), dm, c, s);
	endtask

	// pick a query whose walk stays short, or one that is too long
	task random_query(input int nmax);
		longint      fr[3], to[3], span, dd;
		logic [63:0] n;
		int          kind, ob;
		bit          ok;
		ok = 0;
		for (int t = 0; t < 30 && !ok; t++) begin
			kind = $urandom_range(0, 9);
			span = longint'(sb.eff_step()) * nmax;
			if (span > (64'sd1 << 30)) span = 64'sd1 << 30;
			ob   = (sb.eff_count() > 0) ? $urandom_range(0, sb.eff_count() - 1) : 0;
			for (int d = 0; d < 3; d++) begin
				if (kind < 4) begin
					fr[d] = local_coord();
				end else if (kind < 6) begin
					fr[d] = clamp32(longint'($signed(sb.centre_tab[ob * DIMS_DEF + d]))
						+ longint'($urandom_range(0, 1 << 18)) - (64'sd1 << 17));
				end else if (kind < 8) begin
					fr[d] = longint'($signed($urandom()));
				end else begin
					fr[d] = extreme_coord();
				end
				if (kind == 7) begin
					to[d] = longint'($signed($urandom()));
				end else if (kind >= 8) begin
					to[d] = ($urandom_range(0, 1)) ? fr[d] : extreme_coord();
				end else begin
					dd = longint'($urandom_range(0, 32'(span)));
					if ($urandom_range(0, 1)) dd = -dd;
					if ($urandom_range(0, 9) == 0) dd = 0;
					to[d] = fr[d] + dd;
					if (to[d] != clamp32(to[d])) to[d] = fr[d] - dd;
				end
			end
			n  = sb.step_count(fr, to);
			ok = (n <= nmax) || (n > MAX_STEPS_DEF);
		end
		if (!ok) to = fr;
		send_query(fr, to);
	endtask

	task write_reg(input logic [2:0] idx, input logic [30:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task configure(input logic [1:0] dims, input logic [6:0] count,
			input logic [30:0] rx, input logic [30:0] ry, input logic [30:0] rz,
			input logic [30:0] stp);
		settle();
		write_reg(CFG_ACTIVE_DIMS, 31'(dims));
		write_reg(CFG_OBSTACLE_COUNT, 31'(count));
		write_reg(CFG_ROBOT_SIZE_X, rx);
		write_reg(CFG_ROBOT_SIZE_Y, ry);
		write_reg(CFG_ROBOT_SIZE_Z, rz);
		write_reg(CFG_STEP_LENGTH, stp);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task run_phase(input logic [1:0] dims, input logic [6:0] count,
			input logic [30:0] rx, input logic [30:0] ry, input logic [30:0] rz,
			input logic [30:0] stp, input int nmax, input int items);
		configure(dims, count, rx, ry, rz, stp);
		for (int i = 0; i < items; i++) begin
			rush = (i < 15);
			if ($urandom_range(0, 3) == 0) random_load();
			else random_query(nmax);
		end
		rush = 0;
	endtask

	task directed();
		longint a[3], b[3];
		configure(2'd3, 7'd4, 31'd0, 31'd0, 31'd0, 31'd65536);
		// unit box at the origin as obstacle 0
		for (int d = 0; d < 3; d++) send_load(6'd0, 2'(d), 32'd0, 31'd65536);
		// out-of-range dimension writes nothing
		send_load(6'd0, 2'd3, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		// field extremes on an obstacle outside the count
		send_load(6'd5, 2'd0, 32'h8000_0000, 31'd0);
		send_load(6'd5, 2'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		// zero-length query inside the box
		a = '{0, 0, 0}; b = '{0, 0, 0};
		send_query(a, b);
		// walk straight through the box
		a = '{-5 * 65536, 0, 0}; b = '{5 * 65536, 0, 0};
		send_query(a, b);
		// parallel walk that passes beside it
		a = '{-5 * 65536, 3 * 65536, 3 * 65536}; b = '{5 * 65536, 3 * 65536, 3 * 65536};
		send_query(a, b);
		// end point alone inside the box
		a = '{40000, 0, 0}; b = '{0, 0, 0};
		send_query(a, b);
		// short segment far away
		a = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		b = '{64'sd2147483647 - 100, 64'sd2147483647, 64'sd2147483647};
		send_query(a, b);
		// corner to corner: too long
		a = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		b = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		send_query(a, b);
		// short walk at the low edge
		a = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		b = '{-64'sd2147483648 + 3 * 65536, -64'sd2147483648, -64'sd2147483648};
		send_query(a, b);
		// corner to corner with the largest step
		configure(2'd3, 7'd4, 31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF);
		a = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		b = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		send_query(a, b);
		a = '{64'sd2147483647, -64'sd2147483648, 0};
		b = '{-64'sd2147483648, 64'sd2147483647, -1};
		send_query(a, b);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; func = FUNC_LOAD; obstacle_index = '0; dim_index = '0;
		box_center = '0; box_size = '0;
		from_x = '0; from_y = '0; from_z = '0; to_x = '0; to_y = '0; to_z = '0;
		rush = 0; stall_left = 0; cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every table entry so that no query reads an unwritten one
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_load(6'(i / DIMS_DEF), 2'(i % DIMS_DEF), 32'(local_coord()),
				31'($urandom_range(0, 1 << 18)));

		directed();

		run_phase(2'd2, 7'd3, 31'd0, 31'd0, 31'd0, 31'd655, 16, 75);
		run_phase(2'd3, 7'd12, 31'($urandom_range(0, 1 << 17)),
			31'($urandom_range(0, 1 << 17)), 31'($urandom_range(0, 1 << 17)),
			31'd65536, 12, 75);
		run_phase(2'd1, 7'd0, 31'd0, 31'd0, 31'd0, 31'd1, 16, 75);
		run_phase(2'd0, 7'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 16, 75);
		run_phase(2'd3, 7'd64, 31'($urandom()), 31'($urandom_range(0, 1 << 18)),
			31'($urandom_range(0, 1 << 18)), 31'd1 << 20, 3, 75);
		run_phase(2'd3, 7'd127, 31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0, 3, 75);
		run_phase(2'd2, 7'd8, 31'($urandom_range(0, 1 << 18)),
			31'($urandom_range(0, 1 << 18)), 31'd0,
			31'($urandom_range(1, 1 << 22)), 10, 75);
		run_phase(2'd3, 7'd20, 31'd0, 31'd0, 31'd0, 31'd655, 8, 75);

		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sbcc_pkg.sv
sv/sbcc_ctrl.sv
sv/sbcc_dp.sv
sv/segment_box_collision_check_core.sv
bench/testbench.sv
